FILE: hw/rtl/fac_pkg.sv
// Shared types, constants and codes of the fit allocator.
package fac_pkg;

    // Table geometry
    localparam int ADDR_W       = 25;
    localparam int FREE_ENTRIES = 16;
    localparam int FREE_SLOTS   = FREE_ENTRIES + 1;   // one spare slot for the inserted span
    localparam int USED_ENTRIES = 16;
    localparam int FIDX_W       = $clog2(FREE_SLOTS);
    localparam int FCNT_W       = $clog2(FREE_SLOTS + 1);
    localparam int PIDX_W       = $clog2(FREE_ENTRIES);
    localparam int UIDX_W       = $clog2(USED_ENTRIES);
    localparam int UCNT_W       = $clog2(USED_ENTRIES + 1);
    localparam int SCAN_W       = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;

    // Field widths
    localparam int OP_W      = 2;
    localparam int PID_W     = 8;
    localparam int TAG_W     = 8;
    localparam int REQ_W     = 23;
    localparam int ST_W      = 2;
    localparam int FREED_W   = 5;
    localparam int CFG_IDX_W = 1;

    // Sizes
    localparam logic [ADDR_W-1:0] MB_SIZE      = ADDR_W'(64'd1 << 20);
    localparam logic [ADDR_W-1:0] BEST_FIT_CAP = ADDR_W'(64'd15 << 20);
    localparam logic [ADDR_W-1:0] MERGE_RESET  = ADDR_W'(64'd4 << 20);
    localparam int                RESET_BLOCKS = 5;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE_ONE = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_OWNER = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_LIMIT = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [PID_W-1:0] process_id;
        logic [TAG_W-1:0] block_tag;
        logic [REQ_W-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [ADDR_W-1:0]  block_address;
        logic [FREED_W-1:0] freed_count;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture request, clear scan and result
        logic scan_inc;
        logic fit_eval;    // judge free entry at scan index
        logic alloc_commit;
        logic ins;         // snapshot free table, insert used span at scan index
        logic merge_step;
        logic restore;     // undo insert from snapshot
        logic used_remove; // drop used entry at scan index
        logic freed_inc;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic fit_mode;
        logic used_full;
        logic free_end;
        logic used_end;
        logic fits;
        logic fit_found;
        logic owner_match;
        logic zero_span;
        logic merge_more;
        logic overflow;
    } t_sts;

    // Reset layout of the free table: 1,2,2,4,4 MB from 3 MB
    function automatic logic [ADDR_W-1:0] rst_size(input int i);
        logic [ADDR_W-1:0] v;
        unique case (i)
            0:       v = MB_SIZE;
            1, 2:    v = ADDR_W'(MB_SIZE << 1);
            default: v = ADDR_W'(MB_SIZE << 2);
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] rst_start(input int i);
        logic [ADDR_W-1:0] v;
        v = ADDR_W'(MB_SIZE * 3);
        for (int k = 0; k < RESET_BLOCKS; k++) begin
            if (k < i) begin
                v = v + rst_size(k);
            end
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/fac_datapath.sv
// Datapath: free and used tables, scan and merge index, result registers.
module fac_datapath
    import fac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_req                 i_req,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    output t_sts                 o_sts,
    output logic [ADDR_W-1:0]    o_addr,
    output logic [FREED_W-1:0]   o_freed
);

    // Free table with spare slot, and its snapshot
    logic [ADDR_W-1:0] r_fs [FREE_SLOTS];
    logic [ADDR_W-1:0] r_fz [FREE_SLOTS];
    logic [FCNT_W-1:0] r_fn;
    logic [ADDR_W-1:0] n_fs [FREE_SLOTS];
    logic [ADDR_W-1:0] n_fz [FREE_SLOTS];
    logic [FCNT_W-1:0] n_fn;
    logic [ADDR_W-1:0] r_ss [FREE_SLOTS];
    logic [ADDR_W-1:0] r_sz [FREE_SLOTS];
    logic [FCNT_W-1:0] r_sn;

    // Used table
    logic [ADDR_W-1:0] r_us [USED_ENTRIES];
    logic [ADDR_W-1:0] r_uz [USED_ENTRIES];
    logic [PID_W-1:0]  r_up [USED_ENTRIES];
    logic [TAG_W-1:0]  r_ut [USED_ENTRIES];
    logic [UCNT_W-1:0] r_un;
    logic [ADDR_W-1:0] n_us [USED_ENTRIES];
    logic [ADDR_W-1:0] n_uz [USED_ENTRIES];
    logic [PID_W-1:0]  n_up [USED_ENTRIES];
    logic [TAG_W-1:0]  n_ut [USED_ENTRIES];
    logic [UCNT_W-1:0] n_un;

    // Request, config and scan state
    t_req              r_req;
    logic              r_fit_mode;
    logic [ADDR_W-1:0] r_limit;
    logic [SCAN_W-1:0] r_idx;
    logic [FCNT_W-1:0] r_mi;
    logic [FIDX_W-1:0] r_pick;
    logic [ADDR_W-1:0] r_pst;
    logic [ADDR_W-1:0] r_psz;
    logic [ADDR_W-1:0] r_best;
    logic              r_found;
    logic [ADDR_W-1:0] r_addr;
    logic [FREED_W-1:0] r_freed;

    logic [FIDX_W-1:0] fidx;
    logic [UIDX_W-1:0] uidx;
    logic [PIDX_W-1:0] midx;
    logic [ADDR_W-1:0] req_ext;
    logic [ADDR_W-1:0] sel_st, sel_sz, leftover;
    logic              fits, better;
    logic [FREE_SLOTS-1:0]   gt;
    logic [FREE_ENTRIES-1:0] can_merge;
    logic [ADDR_W-1:0] ins_st, ins_sz;

    assign fidx    = r_idx[FIDX_W-1:0];
    assign uidx    = r_idx[UIDX_W-1:0];
    assign midx    = r_mi[PIDX_W-1:0];
    assign req_ext = ADDR_W'(r_req.request_size);

    // Fit check at the scan index
    assign sel_st   = r_fs[fidx];
    assign sel_sz   = r_fz[fidx];
    assign fits     = sel_sz >= req_ext;
    assign leftover = sel_sz - req_ext;
    assign better   = fits && (leftover < r_best);

    assign ins_st = r_us[uidx];
    assign ins_sz = r_uz[uidx];

    // Insert position: entries past the count or above the new start move up
    always_comb begin
        for (int i = 0; i < FREE_SLOTS; i++) begin
            gt[i] = (FCNT_W'(i) >= r_fn) || (r_fs[i] > ins_st);
        end
    end

    // Touch and size limit of each neighbor pair
    always_comb begin
        for (int p = 0; p < FREE_ENTRIES; p++) begin
            can_merge[p] = (({1'b0, r_fs[p]} + {1'b0, r_fz[p]}) == {1'b0, r_fs[p+1]})
                        && (({1'b0, r_fz[p]} + {1'b0, r_fz[p+1]}) <= {1'b0, r_limit});
        end
    end

    // Free table next state
    always_comb begin
        n_fs = r_fs;
        n_fz = r_fz;
        n_fn = r_fn;
        priority if (i_cmd.alloc_commit) begin
            if (r_psz == req_ext) begin
                for (int i = 0; i < FREE_SLOTS - 1; i++) begin
                    if (FIDX_W'(i) >= r_pick) begin
                        n_fs[i] = r_fs[i+1];
                        n_fz[i] = r_fz[i+1];
                    end
                end
                n_fn = r_fn - 1'b1;
            end else begin
                n_fs[r_pick] = r_pst + req_ext;
                n_fz[r_pick] = r_psz - req_ext;
            end
        end else if (i_cmd.ins) begin
            for (int i = 0; i < FREE_SLOTS; i++) begin
                if (gt[i]) begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                        n_fs[i] = r_fs[(i > 0) ? i - 1 : 0];
                        n_fz[i] = r_fz[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_fs[i] = ins_st;
                        n_fz[i] = ins_sz;
                    end
                end
            end
            n_fn = r_fn + 1'b1;
        end else if (i_cmd.merge_step && can_merge[midx]) begin
            for (int i = 0; i < FREE_SLOTS - 1; i++) begin
                if (FCNT_W'(i) == r_mi) begin
                    n_fz[i] = r_fz[i] + r_fz[i+1];
                end else if (FCNT_W'(i) > r_mi) begin
                    n_fs[i] = r_fs[i+1];
                    n_fz[i] = r_fz[i+1];
                end
            end
            n_fn = r_fn - 1'b1;
        end else if (i_cmd.restore) begin
            n_fs = r_ss;
            n_fz = r_sz;
            n_fn = r_sn;
        end else begin
            // hold
        end
    end

    // Used table next state
    always_comb begin
        n_us = r_us;
        n_uz = r_uz;
        n_up = r_up;
        n_ut = r_ut;
        n_un = r_un;
        priority if (i_cmd.alloc_commit) begin
            if (!r_fit_mode) begin
                for (int i = USED_ENTRIES - 1; i > 0; i--) begin
                    n_us[i] = r_us[i-1];
                    n_uz[i] = r_uz[i-1];
                    n_up[i] = r_up[i-1];
                    n_ut[i] = r_ut[i-1];
                end
                n_us[0] = r_pst;
                n_uz[0] = req_ext;
                n_up[0] = r_req.process_id;
                n_ut[0] = r_req.block_tag;
            end else begin
                n_us[r_un[UIDX_W-1:0]] = r_pst;
                n_uz[r_un[UIDX_W-1:0]] = req_ext;
                n_up[r_un[UIDX_W-1:0]] = r_req.process_id;
                n_ut[r_un[UIDX_W-1:0]] = r_req.block_tag;
            end
            n_un = r_un + 1'b1;
        end else if (i_cmd.used_remove) begin
            for (int i = 0; i < USED_ENTRIES - 1; i++) begin
                if (UIDX_W'(i) >= uidx) begin
                    n_us[i] = r_us[i+1];
                    n_uz[i] = r_uz[i+1];
                    n_up[i] = r_up[i+1];
                    n_ut[i] = r_ut[i+1];
                end
            end
            n_un = r_un - 1'b1;
        end else begin
            // hold
        end
    end

    // Table registers; the free table comes out of reset with its initial blocks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FREE_SLOTS; i++) begin
                r_fs[i] <= (i < RESET_BLOCKS) ? rst_start(i) : '0;
                r_fz[i] <= (i < RESET_BLOCKS) ? rst_size(i) : '0;
            end
            r_fn <= FCNT_W'(RESET_BLOCKS);
            r_un <= '0;
        end else begin
            r_fs <= n_fs;
            r_fz <= n_fz;
            r_fn <= n_fn;
            r_un <= n_un;
        end
    end

    always_ff @(posedge i_clk) begin
        r_us <= n_us;
        r_uz <= n_uz;
        r_up <= n_up;
        r_ut <= n_ut;
        if (i_cmd.ins) begin
            r_ss <= r_fs;
            r_sz <= r_fz;
            r_sn <= r_fn;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= 1'b0;
            r_limit    <= MERGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIT_MODE:    r_fit_mode <= i_cfg_wdata[0];
                CFG_MERGE_LIMIT: r_limit    <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Request capture, scan and merge indexes, fit pick, results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_mi    <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req   <= i_req;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_best  <= BEST_FIT_CAP;
                r_addr  <= '0;
                r_freed <= '0;
            end else if (i_cmd.scan_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.fit_eval) begin
                if (!r_fit_mode) begin
                    if (fits && !r_found) begin
                        r_found <= 1'b1;
                        r_pick  <= fidx;
                        r_pst   <= sel_st;
                        r_psz   <= sel_sz;
                    end
                end else if (better) begin
                    r_found <= 1'b1;
                    r_best  <= leftover;
                    r_pick  <= fidx;
                    r_pst   <= sel_st;
                    r_psz   <= sel_sz;
                end
            end
            if (i_cmd.alloc_commit) begin
                r_addr <= r_pst;
            end
            if (i_cmd.freed_inc) begin
                r_freed <= r_freed + 1'b1;
            end
            if (i_cmd.ins) begin
                r_mi <= '0;
            end else if (i_cmd.merge_step && !can_merge[midx]) begin
                r_mi <= r_mi + 1'b1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.op          = r_req.opcode;
        o_sts.fit_mode    = r_fit_mode;
        o_sts.used_full   = r_un >= UCNT_W'(USED_ENTRIES);
        o_sts.free_end    = SCAN_W'(r_fn) <= r_idx;
        o_sts.used_end    = SCAN_W'(r_un) <= r_idx;
        o_sts.fits        = fits;
        o_sts.fit_found   = r_found;
        o_sts.owner_match = (r_up[uidx] == r_req.process_id)
                         && (r_req.opcode == OP_FREE_ALL || r_ut[uidx] == r_req.block_tag);
        o_sts.zero_span   = ins_sz == '0;
        o_sts.merge_more  = (r_mi + 1'b1) < r_fn;
        o_sts.overflow    = r_fn > FCNT_W'(FREE_ENTRIES);
    end

    assign o_addr  = r_addr;
    assign o_freed = r_freed;

    // Checks
    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fn <= FCNT_W'(FREE_SLOTS))
        else $error("free count past spare slot");
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_un <= UCNT_W'(USED_ENTRIES))
        else $error("used count past table depth");
    a_restore_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restore |=> r_fn <= FCNT_W'(FREE_ENTRIES))
        else $error("restore left an overfull free table");

endmodule

FILE: hw/rtl/fac_ctrl.sv
// Controller: sequences allocate, free and terminate transactions.
module fac_ctrl
    import fac_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_sts            i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output logic [ST_W-1:0] o_status
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_ASCAN   = 3'd2;
    localparam logic [2:0] S_ACOMMIT = 3'd3;
    localparam logic [2:0] S_USCAN   = 3'd4;
    localparam logic [2:0] S_MERGE   = 3'd5;

    logic [2:0]      r_state, n_state;
    logic            r_done, n_done;
    logic [ST_W-1:0] r_status, n_status;
    logic            r_any, n_any;
    logic            r_failed, n_failed;
    logic            one;

    assign one = i_sts.op == OP_FREE_ONE;

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        n_any    = r_any;
        n_failed = r_failed;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_any      = 1'b0;
                    n_failed   = 1'b0;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.used_full) begin
                            n_done = 1'b1; n_status = ST_FULL; n_state = S_IDLE;
                        end else begin
                            n_state = S_ASCAN;
                        end
                    end
                    OP_FREE_ONE, OP_FREE_ALL: n_state = S_USCAN;
                    default: begin
                        n_done = 1'b1; n_status = ST_OK; n_state = S_IDLE;
                    end
                endcase
            end
            // Walk the free table; first fit stops on the first hit
            S_ASCAN: begin
                if (i_sts.free_end) begin
                    if (i_sts.fit_found) begin
                        n_state = S_ACOMMIT;
                    end else begin
                        n_done = 1'b1; n_status = ST_NO_FIT; n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.fit_eval = 1'b1;
                    if (!i_sts.fit_mode && i_sts.fits) begin
                        n_state = S_ACOMMIT;
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                    end
                end
            end
            S_ACOMMIT: begin
                o_cmd.alloc_commit = 1'b1;
                n_done = 1'b1; n_status = ST_OK; n_state = S_IDLE;
            end
            // Walk the used table for owner matches
            S_USCAN: begin
                if (i_sts.used_end) begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                    if (one || !r_any) begin
                        n_status = ST_NO_OWNER;
                    end else begin
                        n_status = r_failed ? ST_FULL : ST_OK;
                    end
                end else if (i_sts.owner_match) begin
                    n_any = 1'b1;
                    if (i_sts.zero_span) begin
                        // empty span: dropped, nothing goes to the free table
                        o_cmd.used_remove = 1'b1;
                        o_cmd.freed_inc   = 1'b1;
                        if (one) begin
                            n_done = 1'b1; n_status = ST_OK; n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.ins = 1'b1;
                        n_state   = S_MERGE;
                    end
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            // One merge decision a cycle, then commit or undo the insert
            S_MERGE: begin
                if (i_sts.merge_more) begin
                    o_cmd.merge_step = 1'b1;
                end else if (i_sts.overflow) begin
                    o_cmd.restore = 1'b1;
                    if (one) begin
                        n_done = 1'b1; n_status = ST_FULL; n_state = S_IDLE;
                    end else begin
                        n_failed       = 1'b1;
                        o_cmd.scan_inc = 1'b1;
                        n_state        = S_USCAN;
                    end
                end else begin
                    o_cmd.used_remove = 1'b1;
                    o_cmd.freed_inc   = 1'b1;
                    if (one) begin
                        n_done = 1'b1; n_status = ST_OK; n_state = S_IDLE;
                    end else begin
                        n_state = S_USCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_any    <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_status <= n_status;
            r_any    <= n_any;
            r_failed <= n_failed;
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_status = r_status;

    // Checks
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) != S_IDLE)
        else $error("result strobe without a transaction in flight");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.alloc_commit, o_cmd.ins, o_cmd.merge_step, o_cmd.restore}))
        else $error("conflicting free table commands");

endmodule

FILE: hw/rtl/fit_allocator_with_coalescing.sv
// Top level of the first-fit / best-fit allocator with coalescing.
//
//   channel   handshake             payload
//   request   start, busy           i_req   (opcode, process_id, block_tag, request_size)
//   result    o_done (one cycle)    o_res   (status, block_address, freed_count)
//   config    i_cfg_we              i_cfg_idx, i_cfg_wdata
//
// From acceptance to the result: an allocate ends after the dispatch state when the used
// table is full, else it goes through dispatch, a scan of the free entries, a commit and
// the result; a free goes through dispatch and a scan of the used entries, with a merge
// pass over the free table for the released block; a terminate repeats the merge part
// per released block.
// Reset is synchronous; the free table comes up with its five initial blocks at once.
// The result receiver cannot stall; a new transaction is taken the cycle o_done shows.
module fit_allocator_with_coalescing
    import fac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_done,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata
);

    t_cmd               cmd;
    t_sts               sts;
    logic [ST_W-1:0]    status;
    logic [ADDR_W-1:0]  addr;
    logic [FREED_W-1:0] freed;

    fac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (status)
    );

    fac_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_addr      (addr),
        .o_freed     (freed)
    );

    // Result transaction
    assign o_res.status        = status;
    assign o_res.block_address = addr;
    assign o_res.freed_count   = freed;

endmodule
